// ===== rtl/pds_pkg.sv =====
// Shared types and constants of the periodic downtime scheduler.
package pds_pkg;
	localparam int MaxTasksDefault = 16;
	localparam int TimeW = 40;
	localparam int BlogW = 41;
	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_RESET = 2'd2;
	localparam logic [2:0] CFG_ENABLE = 3'd0;
	localparam logic [2:0] CFG_RND_PER = 3'd1;
	localparam logic [2:0] CFG_RND_DWN = 3'd2;
	localparam logic [2:0] CFG_TICK = 3'd3;
	localparam logic [2:0] CFG_COUNT = 3'd4;
	// Settings word: period, downtime, offset, active value, inactive value.
	localparam int SetW = 160;
	// Runtime word: due time, backlog, total.
	localparam int RunW = TimeW + BlogW + TimeW;

	typedef struct packed {
		logic start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [32:0] rounded;
	} div_rsp_t;
endpackage

// ===== rtl/pds_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module pds_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/pds_round.sv =====
// Bit-serial divider that rounds a value to the nearest multiple of the tick, ties up.
module pds_round (
	input logic clk,
	input logic arst_n,
	input pds_pkg::div_req_t req,
	output pds_pkg::div_rsp_t rsp
);
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] div_q;
	logic [31:0] dvd_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [32:0] rounded_q;
	logic [32:0] trial;
	logic [32:0] rem_up;
	logic [63:0] prod;

	assign trial = {rem_q, dvd_q[31]};
	assign rem_up = {1'b0, rem_q} + {1'b0, rem_q};
	assign prod = ({32'd0, quo_q} + {63'd0, (rem_up >= {1'b0, div_q})})
		* {32'd0, div_q};

	assign rsp.done = done_q;
	assign rsp.rounded = rounded_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= '0;
			div_q <= req.divisor;
			dvd_q <= req.dividend;
		end else if (busy_q && cnt_q != 6'd0) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_q <= 32'(trial - {1'b0, div_q});
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
		if (busy_q && cnt_q == 6'd0) begin
			rounded_q <= prod[32:0];
		end
	end
endmodule

// ===== rtl/periodic_downtime_scheduler.sv =====
// Top level of the periodic downtime scheduler: control sequencer and state memories.
//
// Channel   Direction  Signals
// --------  ---------  -------------------------------------------------------
// config    in         cfg_we, cfg_index, cfg_data (written at once, no wait)
// request   in         start, busy, req_type, task_index, period .. values
// result    out        valid, out_task, active, output_value, changed,
//                      total_inactive, next_due, last (one cycle per word)
//
// A write word is finished when it is accepted; a reset word walks every task with
// one read state and one write state per row. A tick word walks the N tasks in use
// and waits on the bit-serial rounding divider, which runs once for the downtime and
// once for the period of each task. Settings and runtime state live in two RAMs,
// read in the state before use; the running flags are flip-flops so that reset sets
// them at once. The result receiver cannot stall, so a result word is shown for one
// cycle and then dropped.
module periodic_downtime_scheduler #(
	parameter int MAX_TASKS = pds_pkg::MaxTasksDefault
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data,
	input logic start,
	output logic busy,
	input logic [1:0] req_type,
	input logic [3:0] task_index,
	input logic [31:0] period,
	input logic [31:0] downtime,
	input logic [31:0] offset,
	input logic signed [31:0] active_value,
	input logic signed [31:0] inactive_value,
	output logic valid,
	output logic [3:0] out_task,
	output logic active,
	output logic signed [31:0] output_value,
	output logic changed,
	output logic [39:0] total_inactive,
	output logic [39:0] next_due,
	output logic last
);
	localparam int IdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CntW = $clog2(MAX_TASKS + 1);
	localparam int TimeW = pds_pkg::TimeW;
	localparam int BlogW = pds_pkg::BlogW;
	localparam logic [TimeW-1:0] TMax = '1;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_CLR = 9'b000000010,
		ST_READ = 9'b000000100,
		ST_WAIT = 9'b000001000,
		ST_DDIV = 9'b000010000,
		ST_PDIV = 9'b000100000,
		ST_PDONE = 9'b001000000,
		ST_UPD = 9'b010000000,
		ST_OUT = 9'b100000000
	} state_t;

	state_t state_q;

	logic enable_q, rnd_per_q, rnd_dwn_q;
	logic [31:0] tick_q;
	logic [4:0] count_cfg_q;
	logic [TimeW-1:0] now_q;
	logic [MAX_TASKS-1:0] run_q;
	logic [IdxW-1:0] idx_q;
	logic [CntW-1:0] count_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			rnd_per_q <= 1'b1;
			rnd_dwn_q <= 1'b0;
			tick_q <= 32'd1;
			count_cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pds_pkg::CFG_ENABLE: enable_q <= cfg_data[0];
				pds_pkg::CFG_RND_PER: rnd_per_q <= cfg_data[0];
				pds_pkg::CFG_RND_DWN: rnd_dwn_q <= cfg_data[0];
				pds_pkg::CFG_TICK: tick_q <= cfg_data;
				pds_pkg::CFG_COUNT: count_cfg_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Memories.
	logic set_we, run_we;
	logic [IdxW-1:0] set_waddr, run_waddr, raddr;
	logic [pds_pkg::SetW-1:0] set_wdata, set_rdata;
	logic [pds_pkg::RunW-1:0] run_wdata, run_rdata;

	pds_ram #(.Width(pds_pkg::SetW), .Depth(MAX_TASKS)) u_set_ram (
		.clk(clk), .we(set_we), .waddr(set_waddr), .wdata(set_wdata),
		.raddr(raddr), .rdata(set_rdata)
	);
	pds_ram #(.Width(pds_pkg::RunW), .Depth(MAX_TASKS)) u_run_ram (
		.clk(clk), .we(run_we), .waddr(run_waddr), .wdata(run_wdata),
		.raddr(raddr), .rdata(run_rdata)
	);

	logic [31:0] s_per, s_dwn, s_off, s_act, s_ina;
	logic [TimeW-1:0] r_due, r_tot;
	logic signed [BlogW-1:0] r_blog;
	assign {s_per, s_dwn, s_off, s_act, s_ina} = set_rdata;
	assign {r_due, r_blog, r_tot} = run_rdata;
	assign raddr = idx_q;

	// Shared rounding divider.
	pds_pkg::div_req_t dreq;
	pds_pkg::div_rsp_t drsp;
	pds_round u_round (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic [31:0] dclamp;
	assign dclamp = (s_dwn > s_per) ? s_per : s_dwn;

	logic [32:0] dwn_q, per_q;
	logic tick_zero;
	assign tick_zero = (tick_q == 32'd0);

	always_comb begin
		dreq.start = 1'b0;
		dreq.divisor = tick_q;
		dreq.dividend = dclamp;
		if (state_q == ST_WAIT) begin
			dreq.start = 1'b1;
		end else if (state_q == ST_DDIV && drsp.done) begin
			dreq.start = 1'b1;
			dreq.dividend = s_per;
		end
	end

	// Per-task update, computed from the memory words and the rounded times.
	logic [TimeW:0] now_sum;
	logic [32:0] dwn_eff, per_eff;
	logic due;
	logic signed [BlogW+1:0] b1, b2;
	logic signed [BlogW-1:0] blog_a, blog_n;
	logic [TimeW-1:0] due_n, tot_n;
	logic [TimeW:0] due_sum, tot_sum;
	logic run_n;
	logic idx_ok;
	logic [CntW-1:0] count_clamp;

	localparam logic signed [BlogW+1:0] BMax = (BlogW+2)'(TMax);
	localparam logic signed [BlogW+1:0] BMin = -((BlogW+2)'(1) <<< TimeW);

	assign now_sum = {1'b0, now_q} + {9'd0, tick_q};
	assign dwn_eff = (rnd_dwn_q && !tick_zero) ? dwn_q : {1'b0, dclamp};
	assign per_eff = (rnd_per_q && !tick_zero) ? per_q : {1'b0, s_per};
	assign due = r_due < now_q;
	assign idx_ok = ({28'd0, task_index} < 32'(MAX_TASKS));
	assign count_clamp = ({27'd0, count_cfg_q} > 32'(MAX_TASKS)) ?
		CntW'(MAX_TASKS) : CntW'(count_cfg_q);

	always_comb begin
		b1 = (BlogW+2)'(r_blog) + (BlogW+2)'(dwn_eff);
		blog_a = due ? ((b1 > BMax) ? BlogW'(BMax) : BlogW'(b1)) : r_blog;
		due_sum = {1'b0, r_due} + {8'd0, per_eff};
		due_n = due ? (due_sum[TimeW] ? TMax : due_sum[TimeW-1:0]) : r_due;
		run_n = (blog_a <= 0);
		b2 = (BlogW+2)'(blog_a) - (BlogW+2)'({1'b0, tick_q});
		tot_sum = {1'b0, r_tot} + {9'd0, tick_q};
		if (run_n) begin
			blog_n = blog_a;
			tot_n = r_tot;
		end else begin
			blog_n = (b2 < BMin) ? BlogW'(BMin) : BlogW'(b2);
			tot_n = tot_sum[TimeW] ? TMax : tot_sum[TimeW-1:0];
		end
		if (!enable_q) begin
			run_n = 1'b1;
			blog_n = r_blog;
			due_n = r_due;
			tot_n = r_tot;
		end
	end

	// Memory write selection.
	always_comb begin
		set_we = (state_q == ST_IDLE) && start && (req_type == pds_pkg::REQ_WRITE)
			&& idx_ok;
		set_waddr = IdxW'(task_index);
		set_wdata = {period, downtime, offset, active_value, inactive_value};
		run_we = 1'b0;
		run_waddr = idx_q;
		run_wdata = {due_n, blog_n, tot_n};
		if (set_we) begin
			run_we = 1'b1;
			run_waddr = IdxW'(task_index);
			run_wdata = {8'd0, offset, {BlogW{1'b0}}, {TimeW{1'b0}}};
		end else if (state_q == ST_CLR) begin
			run_we = 1'b1;
			run_wdata = {8'd0, s_off, {BlogW{1'b0}}, {TimeW{1'b0}}};
		end else if (state_q == ST_UPD) begin
			run_we = 1'b1;
		end
	end

	assign busy = (state_q != ST_IDLE);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			now_q <= '0;
			run_q <= '1;
			idx_q <= '0;
			count_q <= '0;
			dwn_q <= '0;
			per_q <= '0;
			valid <= 1'b0;
			out_task <= '0;
			active <= 1'b0;
			output_value <= '0;
			changed <= 1'b0;
			total_inactive <= '0;
			next_due <= '0;
			last <= 1'b0;
		end else begin
			valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (start) begin
						case (req_type)
							pds_pkg::REQ_WRITE: begin
								if (idx_ok) begin
									run_q[IdxW'(task_index)] <= 1'b1;
								end
							end
							pds_pkg::REQ_RESET: begin
								now_q <= '0;
								run_q <= '1;
								state_q <= ST_READ;
								count_q <= '0;
							end
							pds_pkg::REQ_TICK: begin
								now_q <= now_sum[TimeW] ? TMax : now_sum[TimeW-1:0];
								count_q <= count_clamp;
								if (count_cfg_q != 5'd0) begin
									state_q <= ST_READ;
								end
							end
							default: ;
						endcase
					end
				end
				ST_READ: begin
					// A zero count here marks the reset sweep.
					state_q <= (count_q == '0) ? ST_CLR : ST_WAIT;
				end
				ST_CLR: begin
					if (CntW'(idx_q) == CntW'(MAX_TASKS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + IdxW'(1);
						state_q <= ST_READ;
					end
				end
				ST_WAIT: state_q <= ST_DDIV;
				ST_DDIV: begin
					if (drsp.done) begin
						dwn_q <= drsp.rounded;
						state_q <= ST_PDIV;
					end
				end
				ST_PDIV: begin
					if (drsp.done) begin
						per_q <= drsp.rounded;
						state_q <= ST_PDONE;
					end
				end
				ST_PDONE: state_q <= ST_UPD;
				ST_UPD: begin
					run_q[idx_q] <= run_n;
					valid <= 1'b1;
					out_task <= 4'(idx_q);
					active <= run_n;
					output_value <= run_n ? s_act : s_ina;
					changed <= run_n != run_q[idx_q];
					total_inactive <= tot_n;
					next_due <= due_n;
					last <= (CntW'(idx_q) + CntW'(1)) == count_q;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if ((CntW'(idx_q) + CntW'(1)) == count_q) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + IdxW'(1);
						state_q <= ST_READ;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
